FILE: rtl/core/escaped_packet_deframer_defines.svh
// assertion macros for the escaped packet deframer
// used by the front and back modules, no other dependencies
`ifndef ESCAPED_PACKET_DEFRAMER_DEFINES_SVH
`define ESCAPED_PACKET_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define EPD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define EPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define EPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EPD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define EPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define EPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/epd_pkg.sv
// types and constants of the escaped packet deframer
// no dependencies
package epd_pkg;

   localparam int unsigned FRONT_FIELDS = 10;
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 1'd1;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ABORT    = 2'd2;

   localparam logic [1:0] REPLY_NONE     = 2'd0;
   localparam logic [1:0] REPLY_RECEIVED = 2'd1;
   localparam logic [1:0] REPLY_MISMATCH = 2'd2;

   localparam logic [7:0] RECEIPT_WANTED = 8'd1;

   localparam logic [15:0] FLD_SEQ_END  = 16'd3;
   localparam logic [15:0] FLD_RECEIPT  = 16'd4;
   localparam logic [15:0] FLD_ID_END   = 16'd6;
   localparam logic [15:0] FLD_PRIORITY = 16'd7;
   localparam logic [15:0] FLD_LAST     = 16'(FRONT_FIELDS - 1);

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_FIELDS = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   typedef struct packed {
      logic       timeout;
      logic       hdr_hit;
      logic       esc_hit;
      logic [7:0] raw;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage

FILE: rtl/core/epd_req_if.sv
// input channel of the deframer: raw link bytes and timeout events
// no dependencies
interface epd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink (input valid, input command, input rx_byte, output ready);
endinterface

FILE: rtl/core/epd_rsp_if.sv
// result channel of the deframer: payload, completion and abort items
// no dependencies
interface epd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  payload_byte;
   logic [31:0] seq_num;
   logic [7:0]  receipt_code;
   logic [15:0] message_id;
   logic [7:0]  priority_res;
   logic [15:0] data_len;
   logic        sum_ok;
   logic [1:0]  reply_due;
   logic        last;

   modport source (output valid, output result_kind, output payload_byte,
                   output seq_num, output receipt_code, output message_id,
                   output priority_res, output data_len, output sum_ok,
                   output reply_due, output last, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input seq_num, input receipt_code, input message_id,
                 input priority_res, input data_len, input sum_ok,
                 input reply_due, input last, output ready);
endinterface

FILE: rtl/core/epd_front.sv
// front of the deframer: config registers, byte classification, item queue
// depends on epd_pkg, epd_req_if and the defines header
`include "escaped_packet_deframer_defines.svh"

module epd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [epd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_write_data,
   epd_req_if.sink                       req_chan,
   output epd_pkg::queue_type            queue_out,
   input  logic                          pop
);

   logic [7:0] header_ff;
   logic [7:0] escape_ff;
   epd_pkg::item_type entry_ff [epd_pkg::QUEUE_DEPTH];
   logic [epd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [epd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [epd_pkg::QCNT_W-1:0] count_ff, count_in;
   epd_pkg::item_type cls;
   logic push;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= 8'd0;
         escape_ff <= 8'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            epd_pkg::CSR_HEADER: header_ff <= csr_write_data;
            epd_pkg::CSR_ESCAPE: escape_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cls.timeout = req_chan.command;
      cls.hdr_hit = req_chan.rx_byte == header_ff;
      cls.esc_hit = req_chan.rx_byte == escape_ff;
      cls.raw     = req_chan.rx_byte;
   end

   assign req_chan.ready = count_ff != epd_pkg::QUEUE_FULL;
   assign push = req_chan.valid && req_chan.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   assign queue_out.valid = count_ff != '0;
   assign queue_out.item  = entry_ff[rd_ptr_ff];

   `EPD_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= epd_pkg::QUEUE_FULL)
   `EPD_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, count_ff != '0)
   `EPD_ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, count_ff != '0)

endmodule

FILE: rtl/core/epd_back.sv
// back of the deframer: packet state machine and result register
// depends on epd_pkg, epd_rsp_if and the defines header
`include "escaped_packet_deframer_defines.svh"

module epd_back (
   input  logic               clock,
   input  logic               reset,
   input  epd_pkg::queue_type queue_in,
   output logic               pop,
   epd_rsp_if.source          rsp_chan
);

   epd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic        esc_ff, esc_in;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] seq_ff, seq_in;
   logic [7:0]  receipt_ff, receipt_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  prio_ff, prio_in;
   logic [15:0] length_ff, length_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  payload_ff, payload_in;
   logic [31:0] rseq_ff, rseq_in;
   logic [7:0]  rreceipt_ff, rreceipt_in;
   logic [15:0] rid_ff, rid_in;
   logic [7:0]  rprio_ff, rprio_in;
   logic [15:0] rlength_ff, rlength_in;
   logic        ok_ff, ok_in;
   logic [1:0]  reply_ff, reply_in;
   logic        last_ff, last_in;

   logic       result_load;
   logic [7:0] b;

   assign pop = queue_in.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign b   = queue_in.item.raw + {7'd0, esc_ff};

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      esc_in      = esc_ff;
      xor_in      = xor_ff;
      seq_in      = seq_ff;
      receipt_in  = receipt_ff;
      id_in       = id_ff;
      prio_in     = prio_ff;
      length_in   = length_ff;
      result_load = 1'b0;
      kind_in     = epd_pkg::KIND_PAYLOAD;
      payload_in  = 8'd0;
      rseq_in     = 32'd0;
      rreceipt_in = 8'd0;
      rid_in      = 16'd0;
      rprio_in    = 8'd0;
      rlength_in  = 16'd0;
      ok_in       = 1'b0;
      reply_in    = epd_pkg::REPLY_NONE;
      last_in     = 1'b0;
      if (pop) begin
         unique case (phase_ff)
            epd_pkg::PH_FIELDS, epd_pkg::PH_DATA: begin
               if (queue_in.item.timeout) begin
                  phase_in    = epd_pkg::PH_HUNT;
                  count_in    = 16'd0;
                  esc_in      = 1'b0;
                  xor_in      = 8'd0;
                  result_load = 1'b1;
                  kind_in     = epd_pkg::KIND_ABORT;
                  last_in     = 1'b1;
               end else if (queue_in.item.esc_hit) begin
                  esc_in = 1'b1;
               end else if (phase_ff == epd_pkg::PH_FIELDS) begin
                  esc_in = 1'b0;
                  xor_in = xor_ff ^ b;
                  if (count_ff <= epd_pkg::FLD_SEQ_END) begin
                     seq_in = {seq_ff[23:0], b};
                  end else if (count_ff == epd_pkg::FLD_RECEIPT) begin
                     receipt_in = b;
                  end else if (count_ff <= epd_pkg::FLD_ID_END) begin
                     id_in = {id_ff[7:0], b};
                  end else if (count_ff == epd_pkg::FLD_PRIORITY) begin
                     prio_in = b;
                  end else begin
                     length_in = {length_ff[7:0], b};
                  end
                  if (count_ff == epd_pkg::FLD_LAST) begin
                     phase_in = epd_pkg::PH_DATA;
                     count_in = 16'd0;
                  end else begin
                     count_in = count_ff + 16'd1;
                  end
               end else if (count_ff < length_ff) begin
                  esc_in      = 1'b0;
                  xor_in      = xor_ff ^ b;
                  count_in    = count_ff + 16'd1;
                  result_load = 1'b1;
                  kind_in     = epd_pkg::KIND_PAYLOAD;
                  payload_in  = b;
               end else begin
                  phase_in    = epd_pkg::PH_HUNT;
                  count_in    = 16'd0;
                  esc_in      = 1'b0;
                  xor_in      = 8'd0;
                  result_load = 1'b1;
                  kind_in     = epd_pkg::KIND_COMPLETE;
                  rseq_in     = seq_ff;
                  rreceipt_in = receipt_ff;
                  rid_in      = id_ff;
                  rprio_in    = prio_ff;
                  rlength_in  = length_ff;
                  ok_in       = b == xor_ff;
                  if (receipt_ff == epd_pkg::RECEIPT_WANTED) begin
                     reply_in = ok_in ? epd_pkg::REPLY_RECEIVED : epd_pkg::REPLY_MISMATCH;
                  end
                  last_in     = 1'b1;
               end
            end
            default: begin
               if (!queue_in.item.timeout && queue_in.item.hdr_hit) begin
                  phase_in = epd_pkg::PH_FIELDS;
                  count_in = 16'd0;
                  esc_in   = 1'b0;
                  xor_in   = queue_in.item.raw;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= epd_pkg::PH_HUNT;
         count_ff     <= 16'd0;
         esc_ff       <= 1'b0;
         xor_ff       <= 8'd0;
         seq_ff       <= 32'd0;
         receipt_ff   <= 8'd0;
         id_ff        <= 16'd0;
         prio_ff      <= 8'd0;
         length_ff    <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         esc_ff       <= esc_in;
         xor_ff       <= xor_in;
         seq_ff       <= seq_in;
         receipt_ff   <= receipt_in;
         id_ff        <= id_in;
         prio_ff      <= prio_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         kind_ff     <= kind_in;
         payload_ff  <= payload_in;
         rseq_ff     <= rseq_in;
         rreceipt_ff <= rreceipt_in;
         rid_ff      <= rid_in;
         rprio_ff    <= rprio_in;
         rlength_ff  <= rlength_in;
         ok_ff       <= ok_in;
         reply_ff    <= reply_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = kind_ff;
   assign rsp_chan.payload_byte = payload_ff;
   assign rsp_chan.seq_num      = rseq_ff;
   assign rsp_chan.receipt_code = rreceipt_ff;
   assign rsp_chan.message_id   = rid_ff;
   assign rsp_chan.priority_res = rprio_ff;
   assign rsp_chan.data_len     = rlength_ff;
   assign rsp_chan.sum_ok       = ok_ff;
   assign rsp_chan.reply_due    = reply_ff;
   assign rsp_chan.last         = last_ff;

   `EPD_ASSERT_IMPLY(a_hunt_clean, clock, reset,
      phase_ff == epd_pkg::PH_HUNT,
      !esc_ff && count_ff == 16'd0 && xor_ff == 8'd0)
   `EPD_ASSERT_NEXT(a_end_hunts, clock, reset,
      result_load && kind_in != epd_pkg::KIND_PAYLOAD,
      phase_ff == epd_pkg::PH_HUNT)
   `EPD_ASSERT_IMPLY(a_last_kind, clock, reset,
      rsp_valid_ff, last_ff == (kind_ff != epd_pkg::KIND_PAYLOAD))

endmodule

FILE: rtl/core/escaped_packet_deframer.sv
// escaped packet deframer top level: front classifier and queue, back parser
// an accepted item is stored in the front queue, then the back parses it into the registered result
// throughput: one item per cycle unless the result side stalls, set by the byte update in the back
// reset clears phase, counters, checksum, held fields, queue and result valid
// depends on epd_pkg, epd_req_if, epd_rsp_if, epd_front and epd_back
module escaped_packet_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [epd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_write_data,
   epd_req_if.sink                       req_chan,
   epd_rsp_if.source                     rsp_chan
);

   epd_pkg::queue_type queue;
   logic pop;

   epd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .queue_out      (queue),
      .pop            (pop)
   );

   epd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .queue_in (queue),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for escaped_packet_deframer: directed table, then random packets
// depends on epd_pkg, epd_req_if, epd_rsp_if and the deframer rtl
module tb_top;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;
   localparam int   DRAIN_CYCLES = 4;
   localparam int   PHASE_ITEMS  = 440;

   typedef enum logic [1:0] {ROW_LINK, ROW_SET_HEADER, ROW_SET_ESCAPE} row_kind_type;
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ABORT} check_mode_type;

   typedef struct packed {
      row_kind_type   kind;
      logic           cmd;
      logic [7:0]     data;
      check_mode_type check;
   } step_row_type;

   typedef struct packed {
      logic           cmd;
      logic [7:0]     data;
      check_mode_type check;
   } link_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload;
      logic [31:0] seq;
      logic [7:0]  receipt;
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] len;
      logic        ok;
      logic [1:0]  reply;
      logic        last;
   } frame_result_type;

   localparam int NUM_ROWS = 25;
   step_row_type directed_steps [NUM_ROWS] = '{
      '{ROW_LINK,       CMD_TIMEOUT, 8'h00, EXP_NONE},
      '{ROW_LINK,       CMD_BYTE,    8'h5A, EXP_NONE},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_NONE},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_NONE},
      '{ROW_LINK,       CMD_TIMEOUT, 8'hFF, EXP_ABORT},
      '{ROW_SET_HEADER, CMD_BYTE,    8'hFF, EXP_PREDICT},
      '{ROW_SET_ESCAPE, CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'hFF, EXP_NONE},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'hFF, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h12, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h34, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h56, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h01, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'hFF, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h7F, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h80, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'hFF, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h00, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'hFF, EXP_PREDICT},
      '{ROW_LINK,       CMD_BYTE,    8'h71, EXP_PREDICT},
      '{ROW_LINK,       CMD_TIMEOUT, 8'h3C, EXP_NONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_write_en;
   logic [epd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0]                    csr_write_data;

   epd_req_if req_chan();
   epd_rsp_if rsp_chan();

   escaped_packet_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   always #5 clock = ~clock;

   // deframer state mirror
   logic [7:0]         hdr_cfg;
   logic [7:0]         esc_cfg;
   epd_pkg::phase_type frame_phase;
   logic [15:0]        field_idx;
   logic               esc_pend;
   logic [7:0]         xor_acc;
   logic [31:0]        seq_hold;
   logic [7:0]         receipt_hold;
   logic [15:0]        id_hold;
   logic [7:0]         prio_hold;
   logic [15:0]        len_hold;

   link_item_type    link_q [$];
   link_item_type    offered;
   frame_result_type expected_results [$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holdoff_left  = 0;
   bit sender_hold   = 1'b0;
   int link_items    = 0;
   int packet_items  = 0;
   int payload_seen  = 0;
   int complete_seen = 0;
   int bad_sum_seen  = 0;
   int abort_seen    = 0;

   function automatic void restart_hunt();
      frame_phase = epd_pkg::PH_HUNT;
      field_idx   = '0;
      esc_pend    = 1'b0;
      xor_acc     = '0;
   endfunction

   function automatic bit deframe_step(input logic cmd, input logic [7:0] raw,
                                       output frame_result_type res);
      logic [7:0] b;
      res = '0;
      if (frame_phase != epd_pkg::PH_FIELDS && frame_phase != epd_pkg::PH_DATA) begin
         if (cmd == CMD_BYTE && raw == hdr_cfg) begin
            restart_hunt();
            frame_phase = epd_pkg::PH_FIELDS;
            xor_acc = raw;
         end
         return 1'b0;
      end
      if (cmd == CMD_TIMEOUT) begin
         restart_hunt();
         res.kind = epd_pkg::KIND_ABORT;
         res.last = 1'b1;
         return 1'b1;
      end
      if (raw == esc_cfg) begin
         esc_pend = 1'b1;
         return 1'b0;
      end
      b = raw + {7'd0, esc_pend};
      esc_pend = 1'b0;
      if (frame_phase == epd_pkg::PH_FIELDS) begin
         xor_acc ^= b;
         case (field_idx)
            0, 1, 2, 3: seq_hold = {seq_hold[23:0], b};
            4:          receipt_hold = b;
            5, 6:       id_hold = {id_hold[7:0], b};
            7:          prio_hold = b;
            default:    len_hold = {len_hold[7:0], b};
         endcase
         field_idx++;
         if (field_idx >= epd_pkg::FRONT_FIELDS) begin
            frame_phase = epd_pkg::PH_DATA;
            field_idx = '0;
         end
         return 1'b0;
      end
      if (field_idx < len_hold) begin
         xor_acc ^= b;
         field_idx++;
         res.kind = epd_pkg::KIND_PAYLOAD;
         res.payload = b;
         return 1'b1;
      end
      res.kind    = epd_pkg::KIND_COMPLETE;
      res.seq     = seq_hold;
      res.receipt = receipt_hold;
      res.id      = id_hold;
      res.prio    = prio_hold;
      res.len     = len_hold;
      res.ok      = (b == xor_acc);
      if (receipt_hold == epd_pkg::RECEIPT_WANTED) begin
         res.reply = res.ok ? epd_pkg::REPLY_RECEIVED : epd_pkg::REPLY_MISMATCH;
      end else begin
         res.reply = epd_pkg::REPLY_NONE;
      end
      res.last = 1'b1;
      restart_hunt();
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // link side: predict on acceptance, then offer the next item
   always @(posedge clock) begin : link_driver
      frame_result_type predicted;
      bit produced;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            produced = deframe_step(offered.cmd, offered.data, predicted);
            if (offered.check == EXP_NONE) begin
               produced = 1'b0;
            end else if (offered.check == EXP_ABORT) begin
               produced = 1'b1;
               predicted = '0;
               predicted.kind = epd_pkg::KIND_ABORT;
               predicted.last = 1'b1;
            end
            if (produced) expected_results.push_back(predicted);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (link_q.size() != 0 && !sender_hold && $urandom_range(99) >= send_idle_pct) begin
               offered = link_q.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.command <= offered.cmd;
               req_chan.rx_byte <= offered.data;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result side: compare against the oldest expectation, stall at random
   always @(posedge clock) begin : result_monitor
      frame_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item, kind %0d", rsp_chan.result_kind);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", want.kind, rsp_chan.result_kind);
               check_field("payload_byte", want.payload, rsp_chan.payload_byte);
               check_field("seq_num", want.seq, rsp_chan.seq_num);
               check_field("receipt_code", want.receipt, rsp_chan.receipt_code);
               check_field("message_id", want.id, rsp_chan.message_id);
               check_field("priority_res", want.prio, rsp_chan.priority_res);
               check_field("data_len", want.len, rsp_chan.data_len);
               check_field("sum_ok", want.ok, rsp_chan.sum_ok);
               check_field("reply_due", want.reply, rsp_chan.reply_due);
               check_field("last", want.last, rsp_chan.last);
            end
            case (rsp_chan.result_kind)
               epd_pkg::KIND_PAYLOAD: payload_seen++;
               epd_pkg::KIND_COMPLETE: begin
                  complete_seen++;
                  if (!rsp_chan.sum_ok) bad_sum_seen++;
               end
               default: abort_seen++;
            endcase
         end
         if (holdoff_left > 0) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic wait_drained();
      while (link_q.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [epd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == epd_pkg::CSR_HEADER) begin
         hdr_cfg = value;
      end else begin
         esc_cfg = value;
      end
   endtask

   task automatic queue_item(input logic cmd, input logic [7:0] data,
                             input check_mode_type check = EXP_PREDICT);
      while (link_q.size() >= 8) @(posedge clock);
      link_q.push_back('{cmd, data, check});
      link_items++;
   endtask

   task automatic queue_escaped(input logic [7:0] b);
      if (b == esc_cfg || (b != esc_cfg + 8'd1 && $urandom_range(9) == 0)) begin
         repeat (($urandom_range(9) == 0) ? 2 : 1) queue_item(CMD_BYTE, esc_cfg);
         queue_item(CMD_BYTE, b - 8'd1);
      end else begin
         queue_item(CMD_BYTE, b);
      end
   endtask

   task automatic queue_packet(input bit cut);
      logic [7:0] body [$];
      logic [7:0] chk;
      int         len;
      int         stop;
      int         pick;
      int         first;
      first = link_items;
      pick = $urandom_range(99);
      if (pick < 85) len = $urandom_range(8);
      else if (pick < 97) len = $urandom_range(40, 9);
      else len = $urandom_range(300, 250);
      repeat (4) body.push_back(8'($urandom_range(255)));
      body.push_back($urandom_range(1) ? epd_pkg::RECEIPT_WANTED : 8'($urandom_range(255)));
      repeat (3) body.push_back(8'($urandom_range(255)));
      body.push_back(8'(len >> 8));
      body.push_back(8'(len));
      repeat (len) body.push_back(8'($urandom_range(255)));
      chk = hdr_cfg;
      foreach (body[i]) chk ^= body[i];
      if ($urandom_range(4) == 0) chk ^= 8'($urandom_range(255, 1));
      body.push_back(chk);
      stop = cut ? $urandom_range(body.size() - 1) : body.size();
      queue_item(CMD_BYTE, hdr_cfg);
      for (int i = 0; i < stop; i++) queue_escaped(body[i]);
      if (cut) queue_item(CMD_TIMEOUT, 8'($urandom_range(255)));
      packet_items += link_items - first;
   endtask

   initial begin
      int         pick;
      int         start;
      bit         held_off;
      bit         paused;
      logic [7:0] b;
      logic [7:0] next_header;
      logic [7:0] next_escape;

      req_chan.valid   = 1'b0;
      req_chan.command = CMD_BYTE;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = epd_pkg::CSR_HEADER;
      csr_write_data   = '0;
      hdr_cfg      = '0;
      esc_cfg      = '0;
      seq_hold     = '0;
      receipt_hold = '0;
      id_hold      = '0;
      prio_hold    = '0;
      len_hold     = '0;
      restart_hunt();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            ROW_SET_HEADER: write_reg(epd_pkg::CSR_HEADER, directed_steps[i].data);
            ROW_SET_ESCAPE: write_reg(epd_pkg::CSR_ESCAPE, directed_steps[i].data);
            default: queue_item(directed_steps[i].cmd, directed_steps[i].data,
                                directed_steps[i].check);
         endcase
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;  stall_pct = 0;  next_header = 8'h7E; next_escape = 8'h7D;
            end
            1: begin
               send_idle_pct = 64; stall_pct = 0;  next_header = 8'h00; next_escape = 8'hFF;
            end
            2: begin
               send_idle_pct = 0;  stall_pct = 64; next_header = 8'hA5; next_escape = 8'hA5;
            end
            default: begin
               send_idle_pct = 22; stall_pct = 22;
               next_header = 8'($urandom_range(255));
               next_escape = 8'($urandom_range(255));
            end
         endcase
         write_reg(epd_pkg::CSR_HEADER, next_header);
         write_reg(epd_pkg::CSR_ESCAPE, next_escape);
         start = packet_items;
         held_off = 1'b0;
         paused = 1'b0;
         while (packet_items - start < PHASE_ITEMS) begin
            if (p == 0 && !held_off && packet_items - start > 150) begin
               holdoff_left = 80;
               held_off = 1'b1;
            end
            if (p == 0 && !paused && packet_items - start > 300) begin
               sender_hold = 1'b1;
               while (req_chan.valid || expected_results.size() != 0) @(posedge clock);
               sender_hold = 1'b0;
               paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
               queue_packet(1'b0);
            end else if (pick < 80) begin
               queue_packet(1'b1);
            end else if (pick < 88) begin
               repeat ($urandom_range(4, 1)) begin
                  do b = 8'($urandom_range(255)); while (b == hdr_cfg);
                  queue_item(CMD_BYTE, b);
               end
            end else if (pick < 93) begin
               queue_item(CMD_TIMEOUT, 8'($urandom_range(255)));
            end else begin
               // garbage that may open a frame, then flushed by a timeout
               repeat ($urandom_range(6, 1)) queue_item(CMD_BYTE, 8'($urandom_range(255)));
               queue_item(CMD_TIMEOUT, 8'($urandom_range(255)));
            end
         end
      end

      wait_drained();
      $display("covered %0d link items: %0d payload bytes, %0d packets (%0d bad checksum),",
               link_items, payload_seen, complete_seen, bad_sum_seen);
      $display("%0d aborts, 6 header/escape settings, 4 idle/stall mixes, %0d mismatches",
               abort_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
